@@ design/sparse_row_adjacency_table_assert.svh @@
// Assertion macros for the checker module of the adjacency table.
// Each macro places one labeled concurrent assertion, clocked on the rising
// edge and disabled while the asynchronous reset is asserted.
`ifndef SPARSE_ROW_ADJACENCY_TABLE_ASSERT_SVH
`define SPARSE_ROW_ADJACENCY_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRA_ASSERT_SAME(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sparse_row_adjacency_table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRA_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sparse_row_adjacency_table: next-cycle check failed");

`endif

@@ design/sra_pkg.sv @@
`default_nettype none

package sra_pkg;

	// Field widths of the stream payloads.
	localparam int OPCODE_W    = 2;
	localparam int ROW_FIELD_W = 8;
	localparam int COL_FIELD_W = 16;
	localparam int STATUS_W    = 2;
	localparam int POS_W       = 4;
	localparam int CNT_FIELD_W = 5;
	localparam int TOTAL_W     = 13;

	// Default table geometry.
	localparam int DEF_ROWS          = 256;
	localparam int DEF_SLOTS_PER_ROW = 16;
	localparam int DEF_COLUMN_BITS   = 16;

	// Operation codes carried on the input tuser.
	localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

	// Status codes carried on the output tuser.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ROW_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ROW_FULL  = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_COUNT,
		S_SCAN,
		S_WRITE,
		S_DONE
	} state_t;

	// Result payload, packed so that position sits in the lowest bits.
	typedef struct packed {
		logic [COL_FIELD_W-1:0] max_column;
		logic [TOTAL_W-1:0]     total_entries;
		logic [CNT_FIELD_W-1:0] row_count;
		logic                   found;
		logic [POS_W-1:0]       position;
	} out_data_t;

	localparam int OUT_DATA_W  = $bits(out_data_t);
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
	localparam int IN_TDATA_W  = ((ROW_FIELD_W + COL_FIELD_W + 7) / 8) * 8;

	// Bit offsets of the result fields within m_tdata.
	localparam int POS_LSB   = 0;
	localparam int FOUND_BIT = POS_W;
	localparam int CNT_LSB   = POS_W + 1;

endpackage

`default_nettype wire

@@ design/sra_ram.sv @@
`default_nettype none

module sra_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ design/sparse_row_adjacency_table.sv @@
// Sparse matrix pattern kept as fixed-size column lists, one list per row.
// Input stream (s_*): one transfer carries one operation. s_tuser holds the
// opcode (append, insert if absent, lookup); s_tdata holds row and column.
// Output stream (m_*): exactly one result transfer per input transfer, in
// order. m_tuser holds the status; m_tdata holds position, found flag, row
// count, total entry count and largest column added.
// After reset the row counters are swept to zero, one row per cycle, and
// s_tready stays low until the sweep is done. Per item: the row count is
// read, then the row's slots are read one per cycle through the single read
// port of the entry memory, then the new entry is written. An append or an
// empty row skips the scan, a lookup or a hit skips the write, and an
// out-of-range row skips all three steps. Result valid and s_tready rise
// together once the result is registered. A finished result waits in the
// output register while the next item is taken; a stalled receiver holds
// up the block only once a second result is ready to leave.
`default_nettype none

module sparse_row_adjacency_table
	import sra_pkg::*;
#(
	parameter int ROWS          = DEF_ROWS,
	parameter int SLOTS_PER_ROW = DEF_SLOTS_PER_ROW,
	parameter int COLUMN_BITS   = DEF_COLUMN_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// s_tdata fields from bit 0 up: row_index, column_index.
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// s_tuser fields from bit 0 up: opcode.
	input  wire logic [OPCODE_W-1:0]    s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// m_tdata fields from bit 0 up: position, found, row_count,
	// total_entries, max_column, zero fill.
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// m_tuser fields from bit 0 up: status.
	output logic [STATUS_W-1:0]         m_tuser
);

	localparam int RAW     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SLOT_W  = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
	localparam int CNT_W   = $clog2(SLOTS_PER_ROW + 1);
	localparam int ENTRIES = ROWS * SLOTS_PER_ROW;
	localparam int EAW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int TOT_W   = $clog2(ENTRIES + 1);

	// Input fields.
	logic [ROW_FIELD_W-1:0] in_row;
	logic [COL_FIELD_W-1:0] in_col;
	logic                   in_xfer;
	logic                   in_row_ok;

	assign in_row    = s_tdata[ROW_FIELD_W-1:0];
	assign in_col    = s_tdata[ROW_FIELD_W +: COL_FIELD_W];
	assign in_xfer   = s_tvalid && s_tready;
	assign in_row_ok = 32'(in_row) < ROWS;

	// Sequencer and working registers.
	state_t                 state_q, state_d;
	logic [RAW-1:0]         clr_q;
	logic [OPCODE_W-1:0]    op_q;
	logic [RAW-1:0]         row_q;
	logic [COLUMN_BITS-1:0] col_q;
	logic [EAW-1:0]         base_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic [SLOT_W-1:0]      res_pos_q;
	logic                   res_found_q;
	logic [CNT_W-1:0]       res_cnt_q;
	logic [TOT_W-1:0]       total_q;
	logic [COLUMN_BITS-1:0] largest_q;
	logic                   m_valid_q;
	out_data_t              out_data_q;
	logic [STATUS_W-1:0]    out_status_q;

	// Memory ports.
	logic                   cnt_we, cnt_re;
	logic [RAW-1:0]         cnt_waddr;
	logic [CNT_W-1:0]       cnt_wdata, cnt_rd;
	logic                   ent_we, ent_re;
	logic [EAW-1:0]         ent_waddr, ent_raddr;
	logic [COLUMN_BITS-1:0] ent_rd;

	// Derived decisions.
	logic [CNT_W-1:0]  cnt_clamp;
	logic              is_append, is_insert;
	logic              hit;
	logic              scan_last;
	logic              row_full;
	logic              out_free;
	logic [SLOT_W-1:0] scan_slot;

	assign cnt_clamp = (cnt_rd > CNT_W'(SLOTS_PER_ROW)) ? CNT_W'(SLOTS_PER_ROW) : cnt_rd;
	assign is_append = (op_q == OP_APPEND);
	assign is_insert = (op_q == OP_INSERT);
	assign hit       = (ent_rd == col_q);
	assign scan_last = (CNT_W'(slot_q) + CNT_W'(1)) == cnt_q;
	assign row_full  = (cnt_q >= CNT_W'(SLOTS_PER_ROW));
	assign out_free  = !m_valid_q || m_tready;
	assign scan_slot = (state_q == S_SCAN) ? slot_q + SLOT_W'(1) : '0;

	// Per-row entry counters; swept to zero after reset.
	sra_ram #(
		.WIDTH(CNT_W),
		.DEPTH(ROWS)
	) u_count_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re   (cnt_re),
		.raddr(RAW'(in_row)),
		.rdata(cnt_rd)
	);

	// Column entries; a slot may be read before it was written, but only slots below the row count are compared.
	sra_ram #(
		.WIDTH(COLUMN_BITS),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(col_q),
		.re   (ent_re),
		.raddr(ent_raddr),
		.rdata(ent_rd)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == RAW'(ROWS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_xfer) begin
					state_d = in_row_ok ? S_COUNT : S_DONE;
				end
			end
			S_COUNT: begin
				if (is_append) begin
					state_d = S_WRITE;
				end else if (cnt_clamp == '0) begin
					state_d = is_insert ? S_WRITE : S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_DONE;
				end else if (scan_last) begin
					state_d = is_insert ? S_WRITE : S_DONE;
				end
			end
			S_WRITE: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control strobes and memory addressing.
	always_comb begin
		s_tready  = 1'b0;
		cnt_re    = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = row_q;
		cnt_wdata = cnt_q + CNT_W'(1);
		ent_re    = 1'b0;
		ent_we    = 1'b0;
		ent_waddr = base_q + EAW'(cnt_q);
		ent_raddr = base_q + EAW'(scan_slot);
		case (state_q)
			S_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				cnt_wdata = '0;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				cnt_re   = in_xfer;
			end
			S_COUNT: begin
				ent_re = 1'b1;
			end
			S_SCAN: begin
				ent_re = 1'b1;
			end
			S_WRITE: begin
				cnt_we = !row_full;
				ent_we = !row_full;
			end
			S_DONE: begin
				s_tready = 1'b0;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			total_q   <= '0;
			largest_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + RAW'(1);
			end
			// A new entry bumps the total and may raise the largest column.
			if (state_q == S_WRITE && !row_full) begin
				total_q <= total_q + TOT_W'(1);
				if (col_q > largest_q) begin
					largest_q <= col_q;
				end
			end
			// The output register refills from the finished item when it is
			// free, and otherwise empties on a transfer.
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Item and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					op_q         <= s_tuser;
					row_q        <= RAW'(in_row);
					col_q        <= COLUMN_BITS'(in_col);
					base_q       <= EAW'(32'(in_row) * SLOTS_PER_ROW);
					res_status_q <= ST_ROW_RANGE;
					res_pos_q    <= '0;
					res_found_q  <= 1'b0;
					res_cnt_q    <= '0;
				end
			end
			S_COUNT: begin
				cnt_q        <= cnt_clamp;
				slot_q       <= '0;
				res_status_q <= ST_OK;
				res_pos_q    <= '0;
				res_found_q  <= 1'b0;
				res_cnt_q    <= cnt_clamp;
			end
			S_SCAN: begin
				if (hit) begin
					res_pos_q   <= slot_q;
					res_found_q <= 1'b1;
				end else begin
					slot_q <= slot_q + SLOT_W'(1);
				end
			end
			S_WRITE: begin
				if (row_full) begin
					res_status_q <= ST_ROW_FULL;
					res_pos_q    <= '0;
					res_cnt_q    <= cnt_q;
				end else begin
					res_status_q <= ST_OK;
					res_pos_q    <= SLOT_W'(cnt_q);
					res_cnt_q    <= cnt_q + CNT_W'(1);
				end
				res_found_q <= 1'b0;
			end
			S_DONE: begin
				if (out_free) begin
					out_status_q             <= res_status_q;
					out_data_q.position      <= POS_W'(res_pos_q);
					out_data_q.found         <= res_found_q;
					out_data_q.row_count     <= CNT_FIELD_W'(res_cnt_q);
					out_data_q.total_entries <= TOTAL_W'(total_q);
					out_data_q.max_column    <= COL_FIELD_W'(largest_q);
				end
			end
			default: begin
				slot_q <= slot_q;
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_data_q);
	assign m_tuser  = out_status_q;

endmodule

`default_nettype wire

@@ design/sra_checker.sv @@
`default_nettype none

`include "sparse_row_adjacency_table_assert.svh"

module sra_checker
	import sra_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic [STATUS_W-1:0]    m_tuser
);

	logic [POS_W-1:0]       out_pos;
	logic                   out_found;
	logic [CNT_FIELD_W-1:0] out_cnt;

	assign out_pos   = m_tdata[POS_LSB +: POS_W];
	assign out_found = m_tdata[FOUND_BIT];
	assign out_cnt   = m_tdata[CNT_LSB +: CNT_FIELD_W];

	// A stalled result stays offered and unchanged.
	`SRA_ASSERT_NEXT(a_out_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`SRA_ASSERT_NEXT(a_out_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

	// The block works on one item at a time.
	`SRA_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// An out-of-range row reports no slot, no match and an empty count.
	`SRA_ASSERT_SAME(a_range_fields, clk, arst_n, m_tvalid && m_tuser == ST_ROW_RANGE, out_pos == '0 && !out_found && out_cnt == '0)

	// A match is reported only with ok status and at a slot below the count.
	`SRA_ASSERT_SAME(a_found_slot, clk, arst_n, m_tvalid && out_found, m_tuser == ST_OK && CNT_FIELD_W'(out_pos) < out_cnt)

endmodule

bind sparse_row_adjacency_table sra_checker u_sra_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire

@@ tb/sparse_row_adjacency_table_check.sv @@
// Watches both streams of the adjacency table, keeps its own copy of the
// table contents and compares every result transfer with the oldest
// prediction still waiting.
module sparse_row_adjacency_table_check
	import sra_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic [OPCODE_W-1:0]    s_tuser,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	input  wire logic [STATUS_W-1:0]    m_tuser,
	output int                          mismatches,
	output int                          outstanding
);

	localparam int ROW_LIMIT  = DEF_ROWS;
	localparam int SLOT_LIMIT = DEF_SLOTS_PER_ROW;
	localparam int SHOWN_MAX  = 10;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [POS_W-1:0]       position;
		logic                   found;
		logic [CNT_FIELD_W-1:0] row_count;
		logic [TOTAL_W-1:0]     total_entries;
		logic [COL_FIELD_W-1:0] max_column;
	} op_result_t;

	// Shadow copy of the table: per-row fill level and the stored columns.
	logic [CNT_FIELD_W-1:0] row_fill [ROW_LIMIT];
	logic [COL_FIELD_W-1:0] row_columns [ROW_LIMIT][SLOT_LIMIT];
	logic [TOTAL_W-1:0]     entry_count;
	logic [COL_FIELD_W-1:0] widest_column;

	op_result_t awaited_results [$];
	int         fail_total;
	int         result_seq;

	// Applies one operation to the shadow table and returns its result.
	function automatic op_result_t apply_table_op(input logic [OPCODE_W-1:0] op,
			input logic [ROW_FIELD_W-1:0] row, input logic [COL_FIELD_W-1:0] col);
		op_result_t res;
		int         fill;
		int         slot;
		res = '0;
		res.status = ST_OK;
		if (row >= ROW_LIMIT) begin
			res.status = ST_ROW_RANGE;
		end else begin
			fill = row_fill[row];
			res.row_count = CNT_FIELD_W'(fill);
			// Insert and lookup report the first matching slot.
			if (op != OP_APPEND) begin
				for (slot = 0; slot < fill && !res.found; slot++) begin
					if (row_columns[row][slot] == col) begin
						res.found = 1'b1;
						res.position = POS_W'(slot);
					end
				end
			end
			// A hit or a lookup of any kind leaves the table untouched.
			if (!res.found && (op == OP_APPEND || op == OP_INSERT)) begin
				if (fill >= SLOT_LIMIT) begin
					res.status = ST_ROW_FULL;
				end else begin
					row_columns[row][fill] = col;
					row_fill[row] = CNT_FIELD_W'(fill + 1);
					entry_count = entry_count + 1'b1;
					if (col > widest_column)
						widest_column = col;
					res.position = POS_W'(fill);
					res.row_count = CNT_FIELD_W'(fill + 1);
				end
			end
		end
		res.total_entries = entry_count;
		res.max_column = widest_column;
		return res;
	endfunction

	// Results are checked before the operation accepted at the same edge is
	// predicted; a result can never leave in the cycle its request arrives.
	always @(posedge clk or negedge arst_n) begin : track_transfers
		op_result_t got;
		op_result_t want;
		out_data_t  word;
		if (!arst_n) begin
			for (int r = 0; r < ROW_LIMIT; r++)
				row_fill[r] = '0;
			entry_count = '0;
			widest_column = '0;
			awaited_results.delete();
			fail_total = 0;
			result_seq = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				word = out_data_t'(m_tdata[OUT_DATA_W-1:0]);
				got.status = m_tuser;
				got.position = word.position;
				got.found = word.found;
				got.row_count = word.row_count;
				got.total_entries = word.total_entries;
				got.max_column = word.max_column;
				if (awaited_results.size() == 0) begin
					fail_total++;
					if (fail_total <= SHOWN_MAX)
						$display("result %0d arrived with no request waiting: status %0d pos %0d found %0d count %0d total %0d max %0h",
							result_seq, got.status, got.position, got.found,
							got.row_count, got.total_entries, got.max_column);
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						fail_total++;
						if (fail_total <= SHOWN_MAX) begin
							$display("result %0d mismatch (expected / actual):", result_seq);
							$display("  status %0d / %0d  position %0d / %0d  found %0d / %0d",
								want.status, got.status, want.position, got.position,
								want.found, got.found);
							$display("  row_count %0d / %0d  total %0d / %0d  max_column %0h / %0h",
								want.row_count, got.row_count, want.total_entries,
								got.total_entries, want.max_column, got.max_column);
						end
					end
				end
				result_seq++;
			end
			if (s_tvalid && s_tready)
				awaited_results = {awaited_results, apply_table_op(s_tuser,
					s_tdata[ROW_FIELD_W-1:0], s_tdata[ROW_FIELD_W +: COL_FIELD_W])};
			mismatches <= fail_total;
			outstanding <= awaited_results.size();
		end
	end

endmodule

@@ tb/sparse_row_adjacency_table_tb.sv @@
// Drives operations into the adjacency table and gives the verdict; the
// check module beside the block predicts and compares every result.
module sparse_row_adjacency_table_tb;
	import sra_pkg::*;

	// Opcode three has no name in the package and behaves as a lookup.
	localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_OPS  = 425;
	localparam int QUIET_OPS   = 80;
	localparam int HOT_ROWS    = 3;
	localparam int POOL_SIZE   = 20;
	localparam int SET_LENGTH  = 100;
	localparam int DRAIN_WAIT  = 40;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [OPCODE_W-1:0]    s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]    m_tuser;

	int mismatches;
	int outstanding;
	bit quiet_tail = 1'b0;

	logic [ROW_FIELD_W-1:0] hot_rows [HOT_ROWS];
	logic [COL_FIELD_W-1:0] column_pool [POOL_SIZE];

	sparse_row_adjacency_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sparse_row_adjacency_table_check table_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Presents one operation and holds it until the transfer completes.
	// Outside the quiet tail, a random gap may come first.
	task automatic issue_table_op(input logic [OPCODE_W-1:0] op,
			input logic [ROW_FIELD_W-1:0] row, input logic [COL_FIELD_W-1:0] col);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {col, row};
		do @(posedge clk); while (!s_tready);
	endtask

	// The receiver stalls in random bursts until the quiet tail begins.
	initial begin
		forever begin
			if (quiet_tail || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	// Ends the run when no transfer happens on either side for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int                  n;
		int                  pick;
		logic [OPCODE_W-1:0] op;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Empty row: lookups of both kinds miss.
		issue_table_op(OP_LOOKUP, 8'hFF, 16'h0000);
		issue_table_op(OP_SPARE, 8'hFF, 16'h0000);
		// Extreme columns, an insert hit, an insert miss and an appended
		// duplicate that later scans must skip in favor of the first match.
		issue_table_op(OP_APPEND, 8'hFF, 16'hFFFF);
		issue_table_op(OP_APPEND, 8'hFF, 16'h0000);
		issue_table_op(OP_INSERT, 8'hFF, 16'hFFFF);
		issue_table_op(OP_INSERT, 8'hFF, 16'h5555);
		issue_table_op(OP_APPEND, 8'hFF, 16'h0000);
		issue_table_op(OP_LOOKUP, 8'hFF, 16'h0000);
		issue_table_op(OP_SPARE, 8'hFF, 16'h5555);
		// Fill the row to its last slot.
		for (n = 0; n < 12; n++)
			issue_table_op((n % 2 != 0) ? OP_INSERT : OP_APPEND, 8'hFF,
				COL_FIELD_W'(32'hA000 + n));
		// Full row: append and absent insert are refused, hits still work.
		issue_table_op(OP_APPEND, 8'hFF, 16'h0001);
		issue_table_op(OP_INSERT, 8'hFF, 16'h0002);
		issue_table_op(OP_INSERT, 8'hFF, 16'hFFFF);
		issue_table_op(OP_LOOKUP, 8'hFF, 16'hA00B);
		issue_table_op(OP_APPEND, 8'h00, 16'h8000);
		issue_table_op(OP_LOOKUP, 8'h00, 16'h7FFF);

		// Mostly traffic on a few hot rows with a small column pool, so that
		// hits, duplicates and full rows are frequent; the rest is noise.
		for (n = 0; n < RANDOM_OPS; n++) begin
			if (n % SET_LENGTH == 0) begin
				for (int k = 0; k < HOT_ROWS; k++)
					hot_rows[k] = ROW_FIELD_W'($urandom_range(0, 255));
				for (int k = 0; k < POOL_SIZE; k++)
					column_pool[k] = COL_FIELD_W'($urandom_range(0, 65535));
			end
			quiet_tail = (n >= RANDOM_OPS - QUIET_OPS);
			if ($urandom_range(0, 99) < 85) begin
				pick = $urandom_range(0, 99);
				if (pick < 25)
					op = OP_APPEND;
				else if (pick < 65)
					op = OP_INSERT;
				else if (pick < 94)
					op = OP_LOOKUP;
				else
					op = OP_SPARE;
				issue_table_op(op, hot_rows[$urandom_range(0, HOT_ROWS - 1)],
					column_pool[$urandom_range(0, POOL_SIZE - 1)]);
			end else begin
				issue_table_op(OPCODE_W'($urandom_range(OP_APPEND, OP_SPARE)),
					ROW_FIELD_W'($urandom_range(0, 255)),
					COL_FIELD_W'($urandom_range(0, 65535)));
			end
		end
		s_tvalid <= 1'b0;

		// Let the last results drain, then allow for any stray transfer.
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/sra_pkg.sv
design/sra_ram.sv
design/sparse_row_adjacency_table.sv
design/sra_checker.sv
tb/sparse_row_adjacency_table_check.sv
tb/sparse_row_adjacency_table_tb.sv
